/* design/vtp_pkg.sv */
// Shared types, codes, constants and helper functions for the vertex transform projector.
package vtp_pkg;

    localparam int unsigned COORD_W = 24;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned SIN_W   = 31;
    localparam int unsigned PROD_W  = 56;
    localparam int unsigned ACC_W   = 58;
    localparam int unsigned ROT_SHIFT = 30;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint ONE_Q30 = 64'sd1073741824;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_LOAD      = 3'd1,
        OP_TRANSLATE = 3'd2,
        OP_ROTATE    = 3'd3,
        OP_SCALE     = 3'd4
    } vtp_op_t;

    typedef enum logic [1:0] {
        CRD_X = 2'd0,
        CRD_Y = 2'd1,
        CRD_Z = 2'd2
    } vtp_coord_t;

    typedef enum logic [1:0] {
        CF_COS   = 2'd0,
        CF_SIN   = 2'd1,
        CF_NSIN  = 2'd2,
        CF_SCALE = 2'd3
    } vtp_coef_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } vtp_acc_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIG,
        ST_PIV,
        ST_RD,
        ST_LD,
        ST_MUL,
        ST_COMMIT,
        ST_SQRT,
        ST_EMIT
    } vtp_state_t;

    typedef struct packed {
        logic [2:0]          cmd;
        logic signed [23:0]  val_x;
        logic signed [23:0]  val_y;
        logic signed [23:0]  val_z;
        logic [1:0]          axis;
        logic [8:0]          angle_deg;
        logic signed [23:0]  scale_factor;
    } vtp_req_t;

    typedef struct packed {
        logic [5:0]          vertex_index;
        logic signed [23:0]  oblique_u;
        logic signed [23:0]  oblique_v;
        logic signed [23:0]  xy_u;
        logic signed [23:0]  xy_v;
        logic signed [23:0]  xz_u;
        logic signed [23:0]  xz_v;
        logic signed [23:0]  yz_u;
        logic signed [23:0]  yz_v;
        logic                depth_clamped;
        logic                last;
    } vtp_rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic       cap;
        logic       trig;
        logic       rd_en;
        logic       piv;
        logic       ld;
        logic       mul_en;
        vtp_coord_t src;
        vtp_coef_t  coef;
        vtp_acc_t   acc_op;
        logic       wr_en;
        vtp_coord_t dst;
        logic       wr_scale;
        logic       commit;
        logic       load_we;
        logic       emit;
        logic       last;
        vtp_op_t    op;
    } vtp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sq_done;
        logic out_free;
    } vtp_sts_t;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -64'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

    // Fold an angle below 360 onto the first quadrant: {negate, table index}
    function automatic logic [7:0] sin_index(input logic [8:0] a);
        logic [1:0] q;
        logic [8:0] r;
        logic [6:0] idx;
        if (a >= 9'd270)
        begin
            q = 2'd3;
            r = a - 9'd270;
        end
        else if (a >= 9'd180)
        begin
            q = 2'd2;
            r = a - 9'd180;
        end
        else if (a >= 9'd90)
        begin
            q = 2'd1;
            r = a - 9'd90;
        end
        else
        begin
            q = 2'd0;
            r = a;
        end
        idx = q[0] ? 7'(9'd90 - r) : r[6:0];
        return {q[1], idx};
    endfunction

    // Quarter-wave sine in Q30, Taylor series through the x^15 term
    function automatic logic [30:0] sin_quarter(input int unsigned d);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint s;
        x = (longint'(d) * PI_Q30 + 64'd90) / 64'd180;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        s = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x2) >> 30;
            case (n)
                1: term = term / 64'd6;
                2: term = term / 64'd20;
                3: term = term / 64'd42;
                4: term = term / 64'd72;
                5: term = term / 64'd110;
                6: term = term / 64'd156;
                default: term = term / 64'd210;
            endcase
            if (n % 2 == 1)
                s = s - longint'(term);
            else
                s = s + longint'(term);
        end
        if (s < 0)
            s = 0;
        if (s > ONE_Q30)
            s = ONE_Q30;
        return s[30:0];
    endfunction

endpackage

/* design/vtp_sqrt.sv */
// Bit-serial integer square root, two radicand bits per cycle.
module vtp_sqrt #(
    parameter int HALF = 19
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2*HALF-1:0]   rad,
    output logic                done,
    output logic [HALF-1:0]     root
);

    localparam int CW = $clog2(HALF + 1);

    logic [2*HALF-1:0] rad_reg;
    logic [HALF:0]     rem_reg;
    logic [HALF-1:0]   root_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic [HALF+2:0]   rem_try;
    logic [HALF+2:0]   trial;

    assign rem_try = {rem_reg, rad_reg[2*HALF-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(HALF);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (rem_try >= trial)
            begin
                rem_reg  <= (HALF+1)'(rem_try - trial);
                root_reg <= {root_reg[HALF-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_try[HALF:0];
                root_reg <= {root_reg[HALF-2:0], 1'b0};
            end
        end
    end

    assign done = !busy_reg;
    assign root = root_reg;

endmodule

/* design/vtp_dp.sv */
// Datapath: vertex memory, trig lookup, shared multiplier, square root and result register.
module vtp_dp #(
    parameter int MAX_VERTICES = 64,
    parameter int FRAC_BITS    = 16,
    parameter int IW           = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vtp_pkg::vtp_cmd_t  cmd,
    input  logic [IW-1:0]      addr,
    input  vtp_pkg::vtp_req_t  req_data,
    output vtp_pkg::vtp_sts_t  sts,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output vtp_pkg::vtp_rsp_t  rsp_data
);

    localparam int HALF  = (23 + FRAC_BITS) / 2;
    localparam int RAD_W = 2 * HALF;
    localparam int C3 = ((3 << FRAC_BITS) + 5) / 10;
    localparam int C7 = ((7 << FRAC_BITS) + 5) / 10;

    logic signed [23:0] mem_x [MAX_VERTICES];
    logic signed [23:0] mem_y [MAX_VERTICES];
    logic signed [23:0] mem_z [MAX_VERTICES];

    logic [30:0] sin_rom [0:90];

    for (genvar g = 0; g <= 90; g++)
    begin : g_sin
        localparam logic [30:0] SIN_VAL = vtp_pkg::sin_quarter(g);
        assign sin_rom[g] = SIN_VAL;
    end

    logic signed [23:0] dx_reg, dy_reg, dz_reg, fac_reg;
    logic [8:0]         ang_reg;
    logic signed [31:0] sn_reg, cs_reg;
    logic signed [23:0] px_reg, py_reg, pz_reg;
    logic signed [23:0] rdx_reg, rdy_reg, rdz_reg;
    logic signed [23:0] wx_reg, wy_reg, wz_reg;
    logic signed [23:0] nx_reg, ny_reg, nz_reg;
    logic signed [23:0] fx_reg, fy_reg, fz_reg;
    logic signed [55:0] prod_reg;
    logic signed [57:0] acc_reg;
    logic               rsp_valid_reg;
    vtp_pkg::vtp_rsp_t  rsp_reg;

    // Angle reduction and quarter-wave lookup
    logic [8:0] ang_m;
    logic [9:0] ang_c_raw;
    logic [8:0] ang_c;
    logic [7:0] sidx, cidx;
    logic signed [31:0] sin_val, cos_val;

    always_comb
    begin
        ang_m     = (ang_reg >= 9'd360) ? ang_reg - 9'd360 : ang_reg;
        ang_c_raw = {1'b0, ang_m} + 10'd90;
        ang_c     = (ang_c_raw >= 10'd360) ? 9'(ang_c_raw - 10'd360) : ang_c_raw[8:0];
        sidx      = vtp_pkg::sin_index(ang_m);
        cidx      = vtp_pkg::sin_index(ang_c);
        sin_val   = sidx[7] ? -$signed({1'b0, sin_rom[sidx[6:0]]})
                            :  $signed({1'b0, sin_rom[sidx[6:0]]});
        cos_val   = cidx[7] ? -$signed({1'b0, sin_rom[cidx[6:0]]})
                            :  $signed({1'b0, sin_rom[cidx[6:0]]});
    end

    // Multiplier operand selection
    logic signed [23:0] mul_a;
    logic signed [31:0] mul_b;

    always_comb
    begin
        case (cmd.src)
            vtp_pkg::CRD_X: mul_a = wx_reg;
            vtp_pkg::CRD_Y: mul_a = wy_reg;
            default:        mul_a = wz_reg;
        endcase
        case (cmd.coef)
            vtp_pkg::CF_COS:  mul_b = cs_reg;
            vtp_pkg::CF_SIN:  mul_b = sn_reg;
            vtp_pkg::CF_NSIN: mul_b = -sn_reg;
            default:          mul_b = 32'(fac_reg);
        endcase
    end

    // Round the accumulator back to the coordinate format
    logic signed [63:0] acc_ext;
    logic signed [23:0] wr_val;

    always_comb
    begin
        acc_ext = 64'(acc_reg);
        if (cmd.wr_scale)
            wr_val = vtp_pkg::sat24((acc_ext + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        else
            wr_val = vtp_pkg::sat24((acc_ext + (64'sd1 <<< (vtp_pkg::ROT_SHIFT - 1)))
                                    >>> vtp_pkg::ROT_SHIFT);
    end

    // Load values, pivot removed for a rotation
    logic signed [23:0] ldx, ldy, ldz;

    always_comb
    begin
        if (cmd.op == vtp_pkg::OP_ROTATE)
        begin
            ldx = vtp_pkg::sat24(64'(rdx_reg) - 64'(px_reg));
            ldy = vtp_pkg::sat24(64'(rdy_reg) - 64'(py_reg));
            ldz = vtp_pkg::sat24(64'(rdz_reg) - 64'(pz_reg));
        end
        else
        begin
            ldx = rdx_reg;
            ldy = rdy_reg;
            ldz = rdz_reg;
        end
    end

    // Final coordinates of the vertex
    logic signed [23:0] fin_x, fin_y, fin_z;
    logic [RAD_W-1:0]   rad;

    always_comb
    begin
        case (cmd.op)
            vtp_pkg::OP_TRANSLATE:
            begin
                fin_x = vtp_pkg::sat24(64'(wx_reg) + 64'(dx_reg));
                fin_y = vtp_pkg::sat24(64'(wy_reg) + 64'(dy_reg));
                fin_z = vtp_pkg::sat24(64'(wz_reg) + 64'(dz_reg));
            end
            vtp_pkg::OP_ROTATE:
            begin
                fin_x = vtp_pkg::sat24(64'(nx_reg) + 64'(px_reg));
                fin_y = vtp_pkg::sat24(64'(ny_reg) + 64'(py_reg));
                fin_z = vtp_pkg::sat24(64'(nz_reg) + 64'(pz_reg));
            end
            default:
            begin
                fin_x = nx_reg;
                fin_y = ny_reg;
                fin_z = nz_reg;
            end
        endcase
        rad = fin_z[23] ? '0 : RAD_W'({fin_z[22:0]}) << (FRAC_BITS - 1);
    end

    logic            sq_done;
    logic [HALF-1:0] sq_root;

    vtp_sqrt #(.HALF(HALF)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.commit),
        .rad   (rad),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            mem_x[addr] <= req_data.val_x;
            mem_y[addr] <= req_data.val_y;
            mem_z[addr] <= req_data.val_z;
        end
        else if (cmd.commit)
        begin
            mem_x[addr] <= fin_x;
            mem_y[addr] <= fin_y;
            mem_z[addr] <= fin_z;
        end
        if (cmd.rd_en)
        begin
            rdx_reg <= mem_x[addr];
            rdy_reg <= mem_y[addr];
            rdz_reg <= mem_z[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            dx_reg  <= req_data.val_x;
            dy_reg  <= req_data.val_y;
            dz_reg  <= req_data.val_z;
            fac_reg <= req_data.scale_factor;
            ang_reg <= req_data.angle_deg;
        end
        if (cmd.trig)
        begin
            sn_reg <= sin_val;
            cs_reg <= cos_val;
        end
        if (cmd.piv)
        begin
            px_reg <= rdx_reg;
            py_reg <= rdy_reg;
            pz_reg <= rdz_reg;
        end
        if (cmd.ld)
        begin
            wx_reg <= ldx;
            wy_reg <= ldy;
            wz_reg <= ldz;
            nx_reg <= ldx;
            ny_reg <= ldy;
            nz_reg <= ldz;
        end
        else if (cmd.wr_en)
        begin
            case (cmd.dst)
                vtp_pkg::CRD_X: nx_reg <= wr_val;
                vtp_pkg::CRD_Y: ny_reg <= wr_val;
                default:        nz_reg <= wr_val;
            endcase
        end
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        case (cmd.acc_op)
            vtp_pkg::ACC_LOAD: acc_reg <= 58'(prod_reg);
            vtp_pkg::ACC_ADD:  acc_reg <= acc_reg + 58'(prod_reg);
            default:           acc_reg <= acc_reg;
        endcase
        if (cmd.commit)
        begin
            fx_reg <= fin_x;
            fy_reg <= fin_y;
            fz_reg <= fin_z;
        end
    end

    // Projection views
    function automatic logic signed [27:0] quarter(input logic signed [27:0] v);
        return (v + 28'sd2) >>> 2;
    endfunction

    logic signed [27:0] s_ext, x4, y4, z4, ou, ov;
    vtp_pkg::vtp_rsp_t  rsp_next;

    always_comb
    begin
        s_ext = 28'($signed({1'b0, sq_root}));
        x4 = quarter(28'(fx_reg));
        y4 = quarter(28'(fy_reg));
        z4 = quarter(28'(fz_reg));
        ou = quarter(28'(fx_reg) + s_ext);
        ov = quarter(28'(fy_reg) + s_ext);
        rsp_next.vertex_index  = 6'(addr);
        rsp_next.oblique_u     = vtp_pkg::sat24(64'(ou) + 64'(C3));
        rsp_next.oblique_v     = vtp_pkg::sat24(64'(ov) - 64'(C7));
        rsp_next.xy_u          = vtp_pkg::sat24(64'(x4) - 64'(C7));
        rsp_next.xy_v          = vtp_pkg::sat24(64'(y4) + 64'(C3));
        rsp_next.xz_u          = vtp_pkg::sat24(64'(x4) - 64'(C7));
        rsp_next.xz_v          = vtp_pkg::sat24(64'(z4) - 64'(C7));
        rsp_next.yz_u          = vtp_pkg::sat24(64'(y4) + 64'(C3));
        rsp_next.yz_v          = vtp_pkg::sat24(64'(z4) + 64'(C3));
        rsp_next.depth_clamped = fz_reg[23];
        rsp_next.last          = cmd.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.emit)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            rsp_reg <= rsp_next;
    end

    assign sts.sq_done  = sq_done;
    assign sts.out_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp_data     = rsp_reg;

endmodule

/* design/vtp_ctrl.sv */
// Controller: command decode, vertex count and per-vertex step sequencing.
module vtp_ctrl #(
    parameter int MAX_VERTICES = 64,
    parameter int IW           = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [2:0]         req_cmd,
    input  logic [1:0]         req_axis,
    output logic               req_stall,
    output vtp_pkg::vtp_cmd_t  cmd,
    output logic [IW-1:0]      addr,
    input  vtp_pkg::vtp_sts_t  sts
);

    vtp_pkg::vtp_state_t state_reg, state_next;
    logic [6:0]          count_reg, count_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [2:0]          step_reg, step_next;
    vtp_pkg::vtp_op_t    op_reg, op_next;
    logic [1:0]          axis_reg, axis_next;
    logic                is_last;

    assign is_last = (7'(idx_reg) + 7'd1) == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vtp_pkg::ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
            op_reg    <= vtp_pkg::OP_CLEAR;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            op_reg    <= op_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        op_next    = op_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        addr       = idx_reg;
        req_stall  = 1'b1;

        case (state_reg)
            vtp_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.cap   = 1'b1;
                    axis_next = req_axis;
                    idx_next  = '0;
                    case (req_cmd)
                        vtp_pkg::OP_CLEAR:
                            count_next = '0;
                        vtp_pkg::OP_LOAD:
                        begin
                            if (count_reg < 7'(MAX_VERTICES))
                            begin
                                cmd.load_we = 1'b1;
                                addr        = IW'(count_reg);
                                count_next  = count_reg + 7'd1;
                            end
                        end
                        vtp_pkg::OP_TRANSLATE, vtp_pkg::OP_SCALE:
                        begin
                            if (count_reg != '0)
                            begin
                                op_next    = vtp_pkg::vtp_op_t'(req_cmd);
                                state_next = vtp_pkg::ST_RD;
                            end
                        end
                        vtp_pkg::OP_ROTATE:
                        begin
                            if (count_reg != '0)
                            begin
                                op_next    = vtp_pkg::OP_ROTATE;
                                state_next = vtp_pkg::ST_TRIG;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            vtp_pkg::ST_TRIG:
            begin
                // Fetch the pivot while the sine and cosine settle
                cmd.trig   = 1'b1;
                cmd.rd_en  = 1'b1;
                addr       = '0;
                state_next = vtp_pkg::ST_PIV;
            end
            vtp_pkg::ST_PIV:
            begin
                cmd.piv    = 1'b1;
                state_next = vtp_pkg::ST_RD;
            end
            vtp_pkg::ST_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = vtp_pkg::ST_LD;
            end
            vtp_pkg::ST_LD:
            begin
                cmd.ld     = 1'b1;
                step_next  = '0;
                state_next = (op_reg == vtp_pkg::OP_TRANSLATE) ? vtp_pkg::ST_COMMIT
                                                               : vtp_pkg::ST_MUL;
            end
            vtp_pkg::ST_MUL:
            begin
                step_next = step_reg + 3'd1;
                if (op_reg == vtp_pkg::OP_SCALE)
                begin
                    cmd.wr_scale = 1'b1;
                    cmd.coef     = vtp_pkg::CF_SCALE;
                    cmd.mul_en   = step_reg < 3'd3;
                    cmd.src      = vtp_pkg::vtp_coord_t'(step_reg[1:0]);
                    if (step_reg >= 3'd1 && step_reg <= 3'd3)
                        cmd.acc_op = vtp_pkg::ACC_LOAD;
                    if (step_reg >= 3'd2)
                    begin
                        cmd.wr_en = 1'b1;
                        cmd.dst   = vtp_pkg::vtp_coord_t'(2'(step_reg - 3'd2));
                    end
                    if (step_reg == 3'd4)
                        state_next = vtp_pkg::ST_COMMIT;
                end
                else
                begin
                    // Two dot products: products 0,1 give the first axis, 2,3 the second
                    cmd.mul_en = step_reg <= 3'd3;
                    case (axis_reg)
                        vtp_pkg::CRD_X:
                        begin
                            case (step_reg[1:0])
                                2'd0:
                                begin
                                    cmd.src  = vtp_pkg::CRD_Y;
                                    cmd.coef = vtp_pkg::CF_COS;
                                end
                                2'd1:
                                begin
                                    cmd.src  = vtp_pkg::CRD_Z;
                                    cmd.coef = vtp_pkg::CF_NSIN;
                                end
                                2'd2:
                                begin
                                    cmd.src  = vtp_pkg::CRD_Y;
                                    cmd.coef = vtp_pkg::CF_SIN;
                                end
                                default:
                                begin
                                    cmd.src  = vtp_pkg::CRD_Z;
                                    cmd.coef = vtp_pkg::CF_COS;
                                end
                            endcase
                            cmd.dst = (step_reg == 3'd3) ? vtp_pkg::CRD_Y : vtp_pkg::CRD_Z;
                        end
                        vtp_pkg::CRD_Y:
                        begin
                            case (step_reg[1:0])
                                2'd0:
                                begin
                                    cmd.src  = vtp_pkg::CRD_Z;
                                    cmd.coef = vtp_pkg::CF_COS;
                                end
                                2'd1:
                                begin
                                    cmd.src  = vtp_pkg::CRD_X;
                                    cmd.coef = vtp_pkg::CF_NSIN;
                                end
                                2'd2:
                                begin
                                    cmd.src  = vtp_pkg::CRD_Z;
                                    cmd.coef = vtp_pkg::CF_SIN;
                                end
                                default:
                                begin
                                    cmd.src  = vtp_pkg::CRD_X;
                                    cmd.coef = vtp_pkg::CF_COS;
                                end
                            endcase
                            cmd.dst = (step_reg == 3'd3) ? vtp_pkg::CRD_Z : vtp_pkg::CRD_X;
                        end
                        default:
                        begin
                            case (step_reg[1:0])
                                2'd0:
                                begin
                                    cmd.src  = vtp_pkg::CRD_X;
                                    cmd.coef = vtp_pkg::CF_COS;
                                end
                                2'd1:
                                begin
                                    cmd.src  = vtp_pkg::CRD_Y;
                                    cmd.coef = vtp_pkg::CF_SIN;
                                end
                                2'd2:
                                begin
                                    cmd.src  = vtp_pkg::CRD_Y;
                                    cmd.coef = vtp_pkg::CF_COS;
                                end
                                default:
                                begin
                                    cmd.src  = vtp_pkg::CRD_X;
                                    cmd.coef = vtp_pkg::CF_NSIN;
                                end
                            endcase
                            cmd.dst = (step_reg == 3'd3) ? vtp_pkg::CRD_X : vtp_pkg::CRD_Y;
                        end
                    endcase
                    case (step_reg)
                        3'd1, 3'd3: cmd.acc_op = vtp_pkg::ACC_LOAD;
                        3'd2, 3'd4: cmd.acc_op = vtp_pkg::ACC_ADD;
                        default:    cmd.acc_op = vtp_pkg::ACC_HOLD;
                    endcase
                    cmd.wr_en = (step_reg == 3'd3) || (step_reg == 3'd5);
                    if (step_reg == 3'd5)
                        state_next = vtp_pkg::ST_COMMIT;
                end
            end
            vtp_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = vtp_pkg::ST_SQRT;
            end
            vtp_pkg::ST_SQRT:
            begin
                if (sts.sq_done)
                    state_next = vtp_pkg::ST_EMIT;
            end
            vtp_pkg::ST_EMIT:
            begin
                cmd.last = is_last;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (is_last)
                        state_next = vtp_pkg::ST_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = vtp_pkg::ST_RD;
                    end
                end
            end
            default:
                state_next = vtp_pkg::ST_IDLE;
        endcase
    end

endmodule

/* design/vertex_transform_projector_top.sv */
// Top level of the vertex transform projector: controller plus datapath.
// Clear and load take only the accepting cycle; a transform of N vertices stalls requests until
// its last result beat is emitted, a rotation first fetching the sine, cosine and pivot, with
// HALF = (23 + FRAC_BITS) / 2 square-root steps (19 by default); result stalls add to this.
// Per vertex: read, load, 0/5/6 multiply steps, write back, square root, one result beat.
// Reset (rst_n low, asynchronous) empties the store and idles the controller; memory keeps data.
module vertex_transform_projector_top #(
    parameter int MAX_VERTICES = 64,
    parameter int FRAC_BITS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  vtp_pkg::vtp_req_t  req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output vtp_pkg::vtp_rsp_t  rsp_data
);

    // Vertex address width follows the store depth
    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    vtp_pkg::vtp_cmd_t cmd;
    vtp_pkg::vtp_sts_t sts;
    logic [IW-1:0]     addr;

    // Controller: accepts a request beat only when idle, then walks the store
    vtp_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .IW           (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req_data.cmd),
        .req_axis  (req_data.axis),
        .req_stall (req_stall),
        .cmd       (cmd),
        .addr      (addr),
        .sts       (sts)
    );

    // Datapath: holds the result beat in its output register so the walk
    // continues while downstream stalls, up to the next emit
    vtp_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .FRAC_BITS    (FRAC_BITS),
        .IW           (IW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .addr      (addr),
        .req_data  (req_data),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

/* design/vtp_checker.sv */
// Port-level checks for the vertex transform projector, bound to the top level.
module vtp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input vtp_pkg::vtp_req_t req_data,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input vtp_pkg::vtp_rsp_t rsp_data
);

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("result beat changed under stall");

    // A clear leaves requests unstalled in the cycle after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_data.cmd == vtp_pkg::OP_CLEAR |=> !req_stall)
        else $error("clear did not return to idle");

    // A load produces no result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_data.cmd == vtp_pkg::OP_LOAD && !rsp_valid
        |=> !rsp_valid)
        else $error("load produced a result beat");

    // While a non-final beat is pending, the walk is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.last |-> req_stall)
        else $error("request taken before the final beat of a walk");

endmodule

bind vertex_transform_projector_top vtp_checker u_vtp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);
